// ===== rtl/core/hrbp_pkg.sv =====
// Shared types, codes and method name table for the HTTP request byte parser.
package hrbp_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [3:0] {
    PH_METHOD   = 4'd0,
    PH_URI      = 4'd1,
    PH_PROTO    = 4'd2,
    PH_HNAME    = 4'd3,
    PH_HVALUE   = 4'd4,
    PH_BODY     = 4'd5,
    PH_PROTO_CR = 4'd6,
    PH_COLON    = 4'd7,
    PH_VALUE_CR = 4'd8,
    PH_PEEK_CR  = 4'd9,
    PH_PEEK_LF  = 4'd10
  } phase_t;

  localparam logic [2:0] SEC_METHOD = 3'd0;
  localparam logic [2:0] SEC_URI    = 3'd1;
  localparam logic [2:0] SEC_PROTO  = 3'd2;
  localparam logic [2:0] SEC_HNAME  = 3'd3;
  localparam logic [2:0] SEC_HVALUE = 3'd4;
  localparam logic [2:0] SEC_BODY   = 3'd5;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_METHOD = 2'd1;
  localparam logic [1:0] ERR_TRUNC  = 2'd2;

  localparam logic [3:0] CODE_NONE    = 4'd0;
  localparam logic [3:0] CODE_UNKNOWN = 4'd9;
  localparam int         NUM_METHODS  = 9;
  localparam int         NAME_MAX     = 7;

  localparam byte_t CHAR_CR    = 8'h0D;
  localparam byte_t CHAR_LF    = 8'h0A;
  localparam byte_t CHAR_COLON = 8'h3A;
  localparam byte_t CHAR_SPACE = 8'h20;

  // GET HEAD POST PUT DELETE CONNECT OPTIONS TRACE PATCH, zero padded
  localparam byte_t NAME_CHARS [NUM_METHODS][NAME_MAX] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T"},
    '{"O", "P", "T", "I", "O", "N", "S"},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00},
    '{"P", "A", "T", "C", "H", 8'h00, 8'h00}
  };

  localparam logic [3:0] NAME_LEN [NUM_METHODS] = '{
    4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
  };

  typedef struct packed {
    logic       has_byte;
    byte_t      data;
    logic [2:0] section;
    logic       token_done;
    logic [3:0] method_code;
    logic       message_end;
    logic [1:0] error;
    logic       last;
  } res_t;

  typedef struct packed {
    logic push;   // method byte seen
    logic clear;  // method ended or message ended
  } meth_ctl_t;

  function automatic res_t mk_res(logic hb, byte_t d, logic [2:0] sec, logic td,
                                  logic [3:0] mc, logic [1:0] err);
    res_t r;
    r.has_byte    = hb;
    r.data        = d;
    r.section     = sec;
    r.token_done  = td;
    r.method_code = mc;
    r.message_end = 1'b0;
    r.error       = err;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic [2:0] phase_section(phase_t ph);
    logic [2:0] s;
    unique case (ph)
      PH_URI:                             s = SEC_URI;
      PH_PROTO, PH_PROTO_CR:              s = SEC_PROTO;
      PH_HNAME, PH_COLON, PH_PEEK_CR,
      PH_PEEK_LF:                         s = SEC_HNAME;
      PH_HVALUE, PH_VALUE_CR:             s = SEC_HVALUE;
      PH_BODY:                            s = SEC_BODY;
      default:                            s = SEC_METHOD;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/http_request_byte_parser_core.sv =====
// HTTP request byte parser: input register, phase register, step logic and result queue.
// Path: a byte passes the input register, then the result queue, before its first
// result beat can be taken. Throughput: one byte per cycle while the queue has room;
// the queue drains one result per cycle while m_axis_tready is high, so a byte that
// yields two results (CR fallback in header-end lookahead) takes one more out beat.
// Reset: synchronous rst returns the phase to method, empties the queue and input register.
module http_request_byte_parser_core import hrbp_pkg::*; #(
  parameter int METHOD_MAX_CHARS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // data[7:0], token_done, method_code[3:0],
                                      // message_end, error[1:0]
  output logic [3:0]  m_axis_tuser,   // has_byte, section[2:0]
  output logic        m_axis_tlast    // last_of_run
);

  logic       in_valid;
  byte_t      in_byte;
  logic       in_eom;
  phase_t     phase;
  phase_t     phase_next;
  res_t       r0;
  res_t       r1;
  res_t       out_res;
  logic [1:0] n;
  logic [1:0] push_n;
  logic [3:0] method_code;
  meth_ctl_t  ctl;
  meth_ctl_t  ctl_q;
  logic       room;
  logic       step_go;

  assign step_go       = in_valid && room;
  assign s_axis_tready = !in_valid || step_go;
  assign push_n        = step_go ? n : 2'd0;
  assign ctl_q         = step_go ? ctl : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step_go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_eom  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_METHOD;
    end else if (step_go) begin
      phase <= phase_next;
    end
  end

  hrbp_method #(
    .METHOD_MAX_CHARS (METHOD_MAX_CHARS)
  ) u_method (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl_q),
    .data_byte   (in_byte),
    .method_code (method_code)
  );

  hrbp_step u_step (
    .phase       (phase),
    .data_byte   (in_byte),
    .eom         (in_eom),
    .method_code (method_code),
    .phase_next  (phase_next),
    .r0          (r0),
    .r1          (r1),
    .n           (n),
    .ctl         (ctl)
  );

  hrbp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .r0        (r0),
    .r1        (r1),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res),
    .room      (room)
  );

  assign m_axis_tdata = {out_res.error, out_res.message_end, out_res.method_code,
                         out_res.token_done, out_res.data};
  assign m_axis_tuser = {out_res.section, out_res.has_byte};
  assign m_axis_tlast = out_res.last;

  // end of message always returns the parser to the method phase
  a_eom_to_method: assert property (@(posedge clk) disable iff (rst)
    step_go && in_eom |=> phase == PH_METHOD)
    else $error("phase not back to method after end of message");

  // end of message always yields at least a marker beat
  a_eom_has_result: assert property (@(posedge clk) disable iff (rst)
    step_go && in_eom |-> n != 2'd0)
    else $error("end of message produced no result");

  // only the header-end lookahead fallback yields two results
  a_two_only_peek: assert property (@(posedge clk) disable iff (rst)
    step_go && n == 2'd2 |-> phase == PH_PEEK_LF)
    else $error("two results outside header-end lookahead");

  // a run closes with tlast before a new run's first beat can follow a message end
  a_msg_end_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tlast)
    else $error("message end beat without last_of_run");

endmodule

// ===== rtl/core/hrbp_method.sv =====
// Method byte buffer, length/overflow tracking and method name decode.
module hrbp_method import hrbp_pkg::*; #(
  parameter int METHOD_MAX_CHARS = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  meth_ctl_t  ctl,
  input  byte_t      data_byte,
  output logic [3:0] method_code
);

  localparam int LW = $clog2(METHOD_MAX_CHARS + 1);
  localparam int IW = $clog2(METHOD_MAX_CHARS);

  byte_t           chars [METHOD_MAX_CHARS];
  logic [LW-1:0]   length;
  logic            overflow;
  logic            full;
  logic [NUM_METHODS-1:0] match;

  assign full = (length == LW'(METHOD_MAX_CHARS));

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      overflow <= 1'b0;
    end else if (ctl.clear) begin
      length   <= '0;
      overflow <= 1'b0;
    end else if (ctl.push) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        length <= length + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !full) begin
      chars[length[IW-1:0]] <= data_byte;
    end
  end

  // compare all names in parallel; names are distinct so at most one hits
  always_comb begin
    match = '0;
    for (int m = 0; m < NUM_METHODS; m++) begin
      match[m] = (length == LW'(NAME_LEN[m]));
      for (int i = 0; i < NAME_MAX; i++) begin
        if ((4'(i) < NAME_LEN[m]) && (chars[i] != NAME_CHARS[m][i])) begin
          match[m] = 1'b0;
        end
      end
    end
    method_code = CODE_UNKNOWN;
    if (!overflow) begin
      for (int m = NUM_METHODS - 1; m >= 0; m--) begin
        if (match[m]) begin
          method_code = 4'(m);
        end
      end
    end
  end

endmodule

// ===== rtl/core/hrbp_step.sv =====
// Per-byte phase transition and result generation (up to two results per byte).
module hrbp_step import hrbp_pkg::*; (
  input  phase_t     phase,
  input  byte_t      data_byte,
  input  logic       eom,
  input  logic [3:0] method_code,
  output phase_t     phase_next,
  output res_t       r0,
  output res_t       r1,
  output logic [1:0] n,
  output meth_ctl_t  ctl
);

  logic   is_colon;
  phase_t nb_phase;
  res_t   nb_res;
  logic   pending;

  // header name byte handling, shared by the header name phase and the lookahead fallbacks
  assign is_colon = (data_byte == CHAR_COLON);
  assign nb_phase = is_colon ? PH_COLON : PH_HNAME;
  assign nb_res   = mk_res(1'b1, data_byte, SEC_HNAME, 1'b0, CODE_NONE, ERR_NONE);

  always_comb begin
    r0         = '0;
    r1         = '0;
    n          = 2'd0;
    phase_next = phase;
    ctl        = '0;
    pending    = 1'b0;

    unique case (phase)
      PH_URI: begin
        n = 2'd1;
        if (data_byte == CHAR_SPACE) begin
          r0         = mk_res(1'b0, 8'h00, SEC_URI, 1'b1, CODE_NONE, ERR_NONE);
          phase_next = PH_PROTO;
        end else begin
          r0 = mk_res(1'b1, data_byte, SEC_URI, 1'b0, CODE_NONE, ERR_NONE);
        end
      end
      PH_PROTO: begin
        if (data_byte == CHAR_CR) begin
          phase_next = PH_PROTO_CR;
        end else begin
          r0 = mk_res(1'b1, data_byte, SEC_PROTO, 1'b0, CODE_NONE, ERR_NONE);
          n  = 2'd1;
        end
      end
      PH_PROTO_CR: begin
        n = 2'd1;
        if (data_byte == CHAR_LF) begin
          r0         = mk_res(1'b0, 8'h00, SEC_PROTO, 1'b1, CODE_NONE, ERR_NONE);
          phase_next = PH_HNAME;
        end else begin
          r0         = mk_res(1'b1, CHAR_CR, SEC_PROTO, 1'b0, CODE_NONE, ERR_NONE);
          phase_next = PH_PROTO;
        end
      end
      PH_HNAME: begin
        phase_next = nb_phase;
        if (!is_colon) begin
          r0 = nb_res;
          n  = 2'd1;
        end
      end
      PH_COLON: begin
        n = 2'd1;
        if (data_byte == CHAR_SPACE) begin
          r0         = mk_res(1'b0, 8'h00, SEC_HNAME, 1'b1, CODE_NONE, ERR_NONE);
          phase_next = PH_HVALUE;
        end else begin
          r0         = mk_res(1'b1, CHAR_COLON, SEC_HNAME, 1'b0, CODE_NONE, ERR_NONE);
          phase_next = PH_HNAME;
        end
      end
      PH_HVALUE: begin
        if (data_byte == CHAR_CR) begin
          phase_next = PH_VALUE_CR;
        end else begin
          r0 = mk_res(1'b1, data_byte, SEC_HVALUE, 1'b0, CODE_NONE, ERR_NONE);
          n  = 2'd1;
        end
      end
      PH_VALUE_CR: begin
        n = 2'd1;
        if (data_byte == CHAR_LF) begin
          r0         = mk_res(1'b0, 8'h00, SEC_HVALUE, 1'b1, CODE_NONE, ERR_NONE);
          phase_next = PH_PEEK_CR;
        end else begin
          r0         = mk_res(1'b1, CHAR_CR, SEC_HVALUE, 1'b0, CODE_NONE, ERR_NONE);
          phase_next = PH_HVALUE;
        end
      end
      PH_PEEK_CR: begin
        if (data_byte == CHAR_CR) begin
          phase_next = PH_PEEK_LF;
        end else begin
          phase_next = nb_phase;
          if (!is_colon) begin
            r0 = nb_res;
            n  = 2'd1;
          end
        end
      end
      PH_PEEK_LF: begin
        if (data_byte == CHAR_LF) begin
          phase_next = PH_BODY;
        end else begin
          // lone CR falls back to a header name byte
          r0         = mk_res(1'b1, CHAR_CR, SEC_HNAME, 1'b0, CODE_NONE, ERR_NONE);
          n          = 2'd1;
          phase_next = nb_phase;
          if (!is_colon) begin
            r1 = nb_res;
            n  = 2'd2;
          end
        end
      end
      PH_BODY: begin
        r0 = mk_res(1'b1, data_byte, SEC_BODY, 1'b0, CODE_NONE, ERR_NONE);
        n  = 2'd1;
      end
      default: begin
        n = 2'd1;
        if (data_byte == CHAR_SPACE) begin
          r0 = mk_res(1'b0, 8'h00, SEC_METHOD, 1'b1, method_code,
                      (method_code == CODE_UNKNOWN) ? ERR_METHOD : ERR_NONE);
          ctl.clear  = 1'b1;
          phase_next = PH_URI;
        end else begin
          r0         = mk_res(1'b1, data_byte, SEC_METHOD, 1'b0, CODE_NONE, ERR_NONE);
          ctl.push   = 1'b1;
          phase_next = PH_METHOD;
        end
      end
    endcase

    if (eom) begin
      pending = (phase_next >= PH_PROTO_CR) && (phase_next <= PH_PEEK_LF);
      if (n == 2'd0) begin
        r0 = mk_res(1'b0, 8'h00, phase_section(phase_next), 1'b0, CODE_NONE, ERR_NONE);
        n  = 2'd1;
      end
      if (n == 2'd2) begin
        r1.message_end = 1'b1;
        if (pending) r1.error = ERR_TRUNC;
        if (phase_next == PH_BODY) r1.token_done = 1'b1;
      end else begin
        r0.message_end = 1'b1;
        if (pending) r0.error = ERR_TRUNC;
        if (phase_next == PH_BODY) r0.token_done = 1'b1;
      end
      phase_next = PH_METHOD;
      ctl.clear  = 1'b1;
    end

    if (n == 2'd2) begin
      r1.last = 1'b1;
    end else if (n == 2'd1) begin
      r0.last = 1'b1;
    end
  end

endmodule

// ===== rtl/core/hrbp_outq.sv =====
// Four-entry result queue: up to two results in per cycle, one out per ready cycle.
module hrbp_outq import hrbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  res_t       r0,
  input  res_t       r1,
  input  logic       out_ready,
  output logic       out_valid,
  output res_t       out_res,
  output logic       room
);

  res_t       q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic [2:0] count_pop;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;
  assign out_res   = q[rp];
  assign count_pop = count - {2'b00, pop};
  // room for a two-result byte after this cycle's pop
  assign room      = (count_pop <= 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push_n;
      rp    <= rp + {1'b0, pop};
      count <= count_pop + {1'b0, push_n};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q[wp] <= r0;
    if (push_n == 2'd2) q[wp + 2'd1] <= r1;
  end

endmodule
